// File: hdl/rrqs_pkg.sv
`default_nettype none
package rrqs_pkg;

  // Kind of an input request, carried in tuser.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [15:0] SLICE_RESET = 16'd1000;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 144;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request and read the head entry
    logic exec;      // serve the slice, first queue write
    logic arrive;    // append the arriving job after a requeue
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic second;    // the tick needs a second queue write
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/rrqs_ctrl.sv
`default_nettype none
module rrqs_ctrl
  import rrqs_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_ARRIVE = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = in_ready_o && in_valid_i;
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.arrive   = (state_q == ST_ARRIVE);
    cmd_o.out_load = (state_q == ST_HOLD) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.second ? ST_ARRIVE : ST_HOLD;
      end
      ST_ARRIVE: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rrqs_datapath.sv
`default_nettype none
module rrqs_datapath
  import rrqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  cmd_t                  cmd_i,
  output sts_t                        sts_o,
  input  wire  logic                  in_func_i,
  input  wire  logic                  in_arrive_i,
  input  wire  logic [7:0]            in_id_i,
  input  wire  logic [15:0]           in_work_i,
  input  wire  logic                  cfg_we_i,
  input  wire  logic [15:0]           cfg_data_i,
  output logic [OUT_DATA_W-1:0]       out_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] left;
    logic [31:0] cpu;
  } job_t;

  typedef struct packed {
    logic        served;
    logic [7:0]  id;
    logic [15:0] left;
    logic [31:0] cpu;
    logic        done;
    logic [15:0] sidle;
    logic        dropped;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  job_t             mem_q [QUEUE_DEPTH];
  job_t             rd_q;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      idle_q, idle_d, elap_q, elap_d;
  logic [15:0]      slice_q;
  logic             func_q, arrive_q;
  logic [7:0]       id_q;
  logic [15:0]      work_q;
  res_t             res_q, res_d;
  logic [OUT_DATA_W-1:0] out_q;

  logic             is_tick, served, covers, requeue, want_new, fits;
  logic [15:0]      amt, left_new, sidle;
  logic [31:0]      cpu_new;
  logic [CNT_W-1:0] cnt_base;
  logic             wr_en;
  job_t             wr_data, new_job;
  logic [31:0]      cnt_ext;

  assign is_tick  = (func_q == FUNC_TICK);
  assign served   = is_tick && (cnt_q != '0);
  assign covers   = (rd_q.left >= slice_q);
  assign requeue  = served && (rd_q.left > slice_q);
  assign amt      = covers ? slice_q : rd_q.left;
  assign cpu_new  = sat_add(rd_q.cpu, {16'd0, amt});
  assign left_new = covers ? rd_q.left - slice_q : 16'd0;
  // An empty queue idles the whole slice; a job ending early leaves the rest.
  assign sidle    = served ? (covers ? 16'd0 : slice_q - rd_q.left) : slice_q;
  assign new_job  = '{id: id_q, left: work_q, cpu: 32'd0};

  assign sts_o.second = requeue && arrive_q;

  always_comb begin
    cnt_base = cnt_q;
    want_new = 1'b0;
    wr_en    = 1'b0;
    wr_data  = new_job;
    head_d   = head_q;
    idle_d   = idle_q;
    elap_d   = elap_q;
    res_d    = res_q;
    if (cmd_i.exec) begin
      cnt_base = cnt_q - CNT_W'(served);
      want_new = !is_tick || arrive_q;
      if (served) head_d = next_ptr(head_q);
      if (is_tick) begin
        idle_d = sat_add(idle_q, {16'd0, sidle});
        elap_d = sat_add(elap_q, {16'd0, slice_q});
      end
      res_d.served  = served;
      res_d.id      = served ? rd_q.id : 8'd0;
      res_d.left    = served ? left_new : 16'd0;
      res_d.cpu     = served ? cpu_new : 32'd0;
      res_d.done    = served && !requeue;
      res_d.sidle   = is_tick ? sidle : 16'd0;
      res_d.dropped = 1'b0;
    end
    fits = (cnt_base < CNT_FULL);
    if (cmd_i.exec) begin
      if (requeue) begin
        // The job just popped goes back first; an arrival is appended in the following ARRIVE state.
        wr_en   = 1'b1;
        wr_data = '{id: rd_q.id, left: left_new, cpu: cpu_new};
      end else if (want_new) begin
        wr_en         = fits;
        res_d.dropped = !fits;
      end
    end else if (cmd_i.arrive) begin
      wr_en         = fits;
      res_d.dropped = !fits;
    end
    tail_d = wr_en ? next_ptr(tail_q) : tail_q;
    cnt_d  = (cmd_i.exec || cmd_i.arrive) ? cnt_base + CNT_W'(wr_en) : cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[tail_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rd_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= in_func_i;
      arrive_q <= in_arrive_i;
      id_q     <= in_id_i;
      work_q   <= in_work_i;
    end
    res_q <= res_d;
  end

  assign cnt_ext = 32'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {res_q.dropped, cnt_ext[4:0], elap_q, idle_q, res_q.sidle, res_q.done,
                res_q.cpu, res_q.left, res_q.id, res_q.served};
    end
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      idle_q  <= '0;
      elap_q  <= '0;
      slice_q <= SLICE_RESET;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      idle_q <= idle_d;
      elap_q <= elap_d;
      if (cfg_we_i) slice_q <= cfg_data_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/round_robin_quantum_scheduler_top.sv
`default_nettype none
// Round-robin time-slice scheduler. A load request (tuser 0) appends a job to the
// tail of a circular queue of QUEUE_DEPTH entries; a tick request (tuser 1) gives
// the head job one slice, requeues it if work is left, and then appends an arriving
// job when arrive is set. Every request returns one result with the served job,
// the slice's idle time, running idle and elapsed totals, the queue fill and a drop
// flag for an append refused by a full queue. A request passes through IDLE (its
// acceptance and head read), EXEC (serve with one queue write), ARRIVE when a
// requeued job and an arrival both need the single write port of the job memory,
// and HOLD, which loads the result into the output register once it is free. A
// result not yet taken downstream holds the next one back, while the following
// request is already accepted. The user must write the slice length through the
// configuration channel while no request is in flight; the block does not enforce it.
module round_robin_quantum_scheduler_top
  import rrqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  logic                  s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // arrive, new_job_id[7:0], new_job_work[15:0], zero fill
  input  wire  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func
  input  wire  logic [0:0]            s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire  logic                  m_axis_tready_i,
  // served, job_id[7:0], job_left[15:0], job_cpu[31:0], job_done, slice_idle[15:0],
  // idle_sum[31:0], elapsed[31:0], queue_count[4:0], dropped
  output logic [OUT_DATA_W-1:0]       m_axis_tdata_o,
  input  wire  logic                  cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  logic [15:0]           cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_func_i   (s_axis_tuser_i[0]),
    .in_arrive_i (s_axis_tdata_i[0]),
    .in_id_i     (s_axis_tdata_i[8:1]),
    .in_work_i   (s_axis_tdata_i[24:9]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// File: tb/round_robin_quantum_scheduler_top_tb.sv
module round_robin_quantum_scheduler_top_tb;
  import rrqs_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_CYCLES = 300;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] left;
    logic [31:0] cpu;
  } job_t;

  // Same bit layout as the result stream, first member in the top bits.
  typedef struct packed {
    logic        dropped;
    logic [4:0]  queue_count;
    logic [31:0] elapsed;
    logic [31:0] idle_sum;
    logic [15:0] slice_idle;
    logic        job_done;
    logic [31:0] job_cpu;
    logic [15:0] job_left;
    logic [7:0]  job_id;
    logic        served;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [0:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [15:0]           cfg_data_i = '0;

  // Scheduler state as the testbench sees it.
  job_t        run_queue[$];
  logic [15:0] slice_len = SLICE_RESET;
  logic [31:0] idle_acc = '0;
  logic [31:0] elapsed_acc = '0;

  result_t pending_results[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_requests = 0;
  int stall_grants = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int jobs_finished = 0;
  int drops_seen = 0;
  int mismatches = 0;
  int unexpected = 0;

  round_robin_quantum_scheduler_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic try_append(logic [7:0] id, logic [15:0] left, logic [31:0] cpu);
    job_t j;
    if (run_queue.size() >= QUEUE_DEPTH) return 1'b0;
    j.id = id;
    j.left = left;
    j.cpu = cpu;
    run_queue.push_back(j);
    return 1'b1;
  endfunction

  // Advances the scheduler state by one request and returns the result it gives.
  function automatic result_t serve_request(logic func, logic arrive, logic [7:0] id,
                                            logic [15:0] work);
    result_t r;
    job_t    j;
    r = '0;
    if (func == FUNC_LOAD) begin
      r.dropped = !try_append(id, work, '0);
    end else begin
      if (run_queue.size() > 0) begin
        j = run_queue.pop_front();
        r.served = 1'b1;
        r.job_id = j.id;
        if (j.left > slice_len) begin
          r.job_left = j.left - slice_len;
          r.job_cpu = sat_add(j.cpu, {16'd0, slice_len});
          void'(try_append(j.id, r.job_left, r.job_cpu));
        end else if (j.left == slice_len) begin
          r.job_cpu = sat_add(j.cpu, {16'd0, slice_len});
          r.job_done = 1'b1;
        end else begin
          r.slice_idle = slice_len - j.left;
          r.job_cpu = sat_add(j.cpu, {16'd0, j.left});
          r.job_done = 1'b1;
        end
      end else begin
        r.slice_idle = slice_len;
      end
      idle_acc = sat_add(idle_acc, {16'd0, r.slice_idle});
      elapsed_acc = sat_add(elapsed_acc, {16'd0, slice_len});
      if (arrive) r.dropped = !try_append(id, work, '0);
    end
    r.idle_sum = idle_acc;
    r.elapsed = elapsed_acc;
    r.queue_count = 5'(run_queue.size());
    return r;
  endfunction

  function automatic logic [31:0] field_val(logic [OUT_DATA_W-1:0] v, int k);
    case (k)
      0: return {31'd0, v[0]};
      1: return {24'd0, v[8:1]};
      2: return {16'd0, v[24:9]};
      3: return v[56:25];
      4: return {31'd0, v[57]};
      5: return {16'd0, v[73:58]};
      6: return v[105:74];
      7: return v[137:106];
      8: return {27'd0, v[142:138]};
      default: return {31'd0, v[143]};
    endcase
  endfunction

  function automatic string field_name(int k);
    case (k)
      0: return "served";
      1: return "job_id";
      2: return "job_left";
      3: return "job_cpu";
      4: return "job_done";
      5: return "slice_idle";
      6: return "idle_sum";
      7: return "elapsed";
      8: return "queue_count";
      default: return "dropped";
    endcase
  endfunction

  function automatic logic pick_func();
    int load_pct;
    load_pct = (run_queue.size() < 3) ? 60 : 30;
    return ($urandom_range(99) < load_pct) ? FUNC_LOAD : FUNC_TICK;
  endfunction

  // Work values cluster around the slice so that all three serving outcomes show up.
  function automatic logic [15:0] pick_work(int s);
    int v;
    int top;
    case ($urandom_range(3))
      0: v = s + int'($urandom_range(4)) - 2;
      1: begin
        top = (3 * s > 65535) ? 65535 : 3 * s;
        if (top < 1) top = 1;
        v = int'($urandom_range(top, 1));
      end
      2: v = int'($urandom_range(65535, 1));
      default: v = $urandom_range(1) ? 65535 : 1;
    endcase
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic send_request(logic func, logic arrive, logic [7:0] id, logic [15:0] work);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    pending_results.push_back(serve_request(func, arrive, id, work));
    s_axis_tuser_i <= func;
    s_axis_tdata_i <= {7'd0, work, id, arrive};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (func == FUNC_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic send_random_item();
    send_request(pick_func(), 1'($urandom_range(1)), 8'($urandom_range(255)),
                 pick_work(int'(slice_len)));
  endtask

  // The block is already idle again by the time the last result has left.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [15:0] v);
    wait_idle();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slice_len = v;
  endtask

  // Reset slice: empty-queue tick, exact, early and zero-work finishes, a requeue.
  task automatic test_basic_serving();
    send_request(FUNC_TICK, 1'b0, 8'd0, 16'd1);
    send_request(FUNC_LOAD, 1'b0, 8'd0, 16'd1000);
    send_request(FUNC_LOAD, 1'b1, 8'd255, 16'hFFFF);
    send_request(FUNC_LOAD, 1'b0, 8'h5A, 16'd1);
    send_request(FUNC_LOAD, 1'b1, 8'd7, 16'd0);
    send_request(FUNC_TICK, 1'b0, 8'hFF, 16'hFFFF);
    send_request(FUNC_TICK, 1'b0, 8'h00, 16'h0000);
    send_request(FUNC_TICK, 1'b0, 8'hA5, 16'h5A5A);
    send_request(FUNC_TICK, 1'b0, 8'h3C, 16'hC3C3);
    send_request(FUNC_TICK, 1'b1, 8'd3, 16'd2500);
  endtask

  task automatic test_full_queue();
    int k;
    for (k = 0; k < 15; k++) send_request(FUNC_LOAD, 1'b0, 8'(100 + k), 16'd5000);
    send_request(FUNC_TICK, 1'b1, 8'd200, 16'd42);
  endtask

  task automatic test_zero_slice();
    write_slice(16'd0);
    send_request(FUNC_TICK, 1'b0, 8'd1, 16'd1);
    send_request(FUNC_TICK, 1'b1, 8'd2, 16'd2);
  endtask

  task automatic test_random(int count, logic [15:0] slice);
    int sent;
    int burst;
    write_slice(slice);
    sent = 0;
    while (sent < count) begin
      // Now and then a run of loads long enough to overflow the queue.
      burst = ($urandom_range(99) < 3) ? 17 : 1;
      if (burst > 1) begin
        repeat (burst) send_request(FUNC_LOAD, 1'($urandom_range(1)),
                                    8'($urandom_range(255)), pick_work(int'(slice)));
      end else begin
        send_random_item();
      end
      sent += burst;
    end
  endtask

  task automatic test_backpressure();
    write_slice(16'd100);
    stall_requests++;
    repeat (14) send_random_item();
  endtask

  // A few ticks at the widest slice, then a load and a tick.
  task automatic test_wide_slice();
    int n;
    write_slice(16'hFFFF);
    for (n = 0; n < 8; n++) send_request(FUNC_TICK, 1'b0, 8'(n), 16'(n));
    send_request(FUNC_LOAD, 1'b0, 8'd9, 16'd5);
    send_request(FUNC_TICK, 1'b0, 8'd0, 16'd1);
  endtask

  always @(posedge clk_i) begin : drive_sink_ready
    if (stall_grants != stall_requests) begin
      stall_grants = stall_requests;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    logic    bad;
    int      k;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (m_axis_tdata_o[57]) jobs_finished++;
      if (m_axis_tdata_o[143]) drops_seen++;
      if (pending_results.size() == 0) begin
        unexpected++;
        $display("error: result %h arrived with no request outstanding", m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        bad = 1'b0;
        for (k = 0; k < 10; k++)
          if (field_val(want, k) !== field_val(m_axis_tdata_o, k)) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            for (k = 0; k < 10; k++)
              if (field_val(want, k) !== field_val(m_axis_tdata_o, k))
                $display("error: result %0d %s expected %0d got %0d", results_seen,
                         field_name(k), field_val(want, k), field_val(m_axis_tdata_o, k));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("error: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 6;
    sink_idle_pct = 62;
    test_basic_serving();
    test_full_queue();
    test_zero_slice();
    test_random(90, 16'd1);
    test_random(90, 16'd1000);
    test_random(95, 16'd37);

    src_idle_pct = 62;
    sink_idle_pct = 6;
    test_random(90, 16'hFFFF);
    test_random(90, 16'd250);
    test_random(95, 16'd12);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random(90, 16'd500);
    test_random(95, 16'd3);
    test_random(90, 16'd2000);
    test_wide_slice();
    wait_idle();

    $display("summary: %0d loads and %0d ticks sent, %0d results checked, %0d mismatches",
             loads_sent, ticks_sent, results_seen, mismatches);
    $display("summary: %0d jobs finished, %0d appends refused, slices from 0 to 65535",
             jobs_finished, drops_seen);
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
